@@ sv/pcir_pkg.sv @@
`default_nettype none
package pcir_pkg;

	localparam int FIELD_W        = 16;
	localparam int COUNT_W        = 16;
	localparam int VALUE_BITS_DEF = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Status that the remainder unit returns to the sequencer.
	typedef struct packed {
		logic done;
		logic zero;
	} rem_stat_t;

endpackage
`default_nettype wire

@@ sv/pcir_if.sv @@
`default_nettype none
interface pcir_req_if import pcir_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] range_start;
	logic [FIELD_W-1:0] range_end;

	modport source (output valid, output range_start, output range_end, input ready);
	modport sink   (input valid, input range_start, input range_end, output ready);
endinterface

interface pcir_rsp_if import pcir_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] prime_count;

	modport source (output valid, output prime_count, input ready);
	modport sink   (input valid, input prime_count, output ready);
endinterface
`default_nettype wire

@@ sv/pcir_rem_unit.sv @@
`default_nettype none
module pcir_rem_unit import pcir_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [VALUE_BITS-1:0] dividend,
	input  wire logic [VALUE_BITS-1:0] divisor,
	output rem_stat_t                  stat
);

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [VALUE_BITS-1:0] shift_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] div_q;
	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS:0]   diff;

	// One restoring step: bring down the next dividend bit, subtract if it fits.
	assign trial = {rem_q, shift_q[VALUE_BITS-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			div_q   <= divisor;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= diff[VALUE_BITS-1:0];
			end else begin
				rem_q <= trial[VALUE_BITS-1:0];
			end
		end
	end

	assign stat.done = done_q;
	assign stat.zero = (rem_q == '0);

endmodule
`default_nettype wire

@@ sv/prime_count_in_range_core.sv @@
// Counts the primes in the half-open range [range_start, range_end).
// The request channel (req) carries one word with both bounds; the response
// channel (rsp) returns one word with prime_count for every request.
// Both bounds are cut or zero-extended to VALUE_BITS bits before use.
// Every odd candidate from 5 up is tested by trial division with odd divisors
// up to its square root. A single bit-serial remainder unit does all the
// division; each divisor takes a square compare in ST_SQ, which also starts
// the remainder unit, and a wait in ST_DIV for its result. Candidates below 4
// and even candidates are settled in ST_NEXT without any division. For an empty
// range the sequencer goes from ST_NEXT straight to ST_FINISH, which raises
// rsp.valid once the output register is free.
// req.ready is high only while no range is being worked on. The finished
// count sits in an output register, so the next request is taken while the
// receiver still stalls the previous response; a second count waits in the
// final state until that register is free.
// Reset clears the sequencer and drops rsp.valid; no count is kept across it.
`default_nettype none
module prime_count_in_range_core import pcir_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pcir_req_if.sink    req,
	pcir_rsp_if.source  rsp
);

	localparam int SQ_W = VALUE_BITS + 2;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_NEXT   = 5'b00010,
		ST_SQ     = 5'b00100,
		ST_DIV    = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [VALUE_BITS-1:0] hi_q;
	logic [VALUE_BITS-1:0] d_q;
	logic [SQ_W-1:0]       sq_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  out_valid_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic                  rem_start;
	rem_stat_t             rem_stat;
	logic                  out_free;
	logic [COUNT_W-1:0]    count_inc;

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.prime_count = out_count_q;

	assign out_free  = !out_valid_q || rsp.ready;
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
	assign rem_start = (state_q == ST_SQ) && !(sq_q > {2'b00, v_q});

	pcir_rem_unit #(
		.VALUE_BITS (VALUE_BITS)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (v_q),
		.divisor  (d_q),
		.stat     (rem_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (v_q >= hi_q) begin
						state_q <= ST_FINISH;
					end else if (v_q >= VALUE_BITS'(4) && v_q[0]) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (sq_q > {2'b00, v_q}) begin
						state_q <= ST_NEXT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_stat.done) begin
						state_q <= rem_stat.zero ? ST_NEXT : ST_SQ;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				v_q     <= VALUE_BITS'(req.range_start);
				hi_q    <= VALUE_BITS'(req.range_end);
				count_q <= '0;
			end
			ST_NEXT: begin
				if (v_q < hi_q) begin
					if (v_q >= VALUE_BITS'(4) && v_q[0]) begin
						d_q  <= VALUE_BITS'(3);
						sq_q <= SQ_W'(9);
					end else begin
						// Small values and even values are settled at once.
						if (v_q == VALUE_BITS'(2) || v_q == VALUE_BITS'(3)) begin
							count_q <= count_inc;
						end
						v_q <= v_q + 1'b1;
					end
				end
			end
			ST_SQ: begin
				if (sq_q > {2'b00, v_q}) begin
					// No divisor up to the square root: the candidate is prime.
					count_q <= count_inc;
					v_q     <= v_q + 1'b1;
				end
			end
			ST_DIV: begin
				if (rem_stat.done) begin
					if (rem_stat.zero) begin
						v_q <= v_q + 1'b1;
					end else begin
						// (d + 2)^2 = d^2 + 4d + 4
						sq_q <= sq_q + {d_q, 2'b00} + SQ_W'(4);
						d_q  <= d_q + VALUE_BITS'(2);
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_count_q <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

@@ verif/pcir_count_checker.sv @@
module pcir_count_checker import pcir_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	input  wire logic               req_ready,
	input  wire logic [FIELD_W-1:0] range_start,
	input  wire logic [FIELD_W-1:0] range_end,
	input  wire logic               rsp_valid,
	input  wire logic               rsp_ready,
	input  wire logic [COUNT_W-1:0] prime_count,
	output int                      fail_count,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [COUNT_W-1:0] expected_counts[$];
	logic [COUNT_W-1:0] oldest_count;
	int                 fails  = 0;
	int                 queued = 0;

	assign fail_count = fails;
	assign pending    = queued;

	function automatic bit is_prime(longint unsigned v);
		longint unsigned d;
		if (v < 2) return 1'b0;
		if (v < 4) return 1'b1;
		if ((v & 1) == 0) return 1'b0;
		for (d = 3; d * d <= v; d += 2) begin
			if (v % d == 0) return 1'b0;
		end
		return 1'b1;
	endfunction

	// Both bounds are trimmed to the configured value width, and the count
	// saturates at the top of its field.
	function automatic logic [COUNT_W-1:0] count_primes(logic [FIELD_W-1:0] lo_in,
			logic [FIELD_W-1:0] hi_in);
		longint unsigned    mask;
		longint unsigned    lo;
		longint unsigned    hi;
		longint unsigned    v;
		logic [COUNT_W-1:0] n;
		mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 1);
		lo   = longint'(lo_in) & mask;
		hi   = longint'(hi_in) & mask;
		n    = '0;
		for (v = lo; v < hi; v++) begin
			if (is_prime(v) && n < COUNT_MAX) n++;
		end
		return n;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			// The response is matched first, so a word taken in the same cycle
			// never answers itself.
			if (rsp_valid && rsp_ready) begin
				if (expected_counts.size() == 0) begin
					$error("prime_count: expected none, actual %0d", prime_count);
					fails++;
				end else begin
					oldest_count = expected_counts.pop_front();
					if (prime_count !== oldest_count) begin
						$error("prime_count: expected %0d, actual %0d", oldest_count,
							prime_count);
						fails++;
					end
				end
			end
			if (req_valid && req_ready)
				expected_counts.push_back(count_primes(range_start, range_end));
		end
		queued = expected_counts.size();
	end

endmodule

@@ verif/tb_prime_count_in_range_core.sv @@
module tb_prime_count_in_range_core import pcir_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	bit   tx_idle_en  = 1'b1;
	bit   rx_idle_en  = 1'b1;
	bit   hold_rsp_go = 1'b0;

	pcir_req_if req_if ();
	pcir_rsp_if rsp_if ();

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	prime_count_in_range_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	pcir_count_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_if.valid),
		.req_ready   (req_if.ready),
		.range_start (req_if.range_start),
		.range_end   (req_if.range_end),
		.rsp_valid   (rsp_if.valid),
		.rsp_ready   (rsp_if.ready),
		.prime_count (rsp_if.prime_count),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// Response side: random stalls, plus one long hold-off counted here.
	initial begin
		int stall_left;
		stall_left   = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp_go) begin
				hold_rsp_go = 1'b0;
				stall_left  = 600;
			end
			if (!arst_n) begin
				rsp_if.ready = 1'b0;
			end else if (stall_left > 0) begin
				rsp_if.ready = 1'b0;
				stall_left--;
			end else begin
				rsp_if.ready = !rx_idle_en || ($urandom_range(0, 99) >= 25);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_range(input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi);
		while (tx_idle_en && $urandom_range(0, 99) < 25) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid       = 1'b1;
		req_if.range_start = lo;
		req_if.range_end   = hi;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_if.valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Mostly short well-formed ranges anywhere in the value space; some start
	// near zero, a few are wide but low, and the rest are empty or reversed.
	task automatic pick_range(output logic [FIELD_W-1:0] lo, output logic [FIELD_W-1:0] hi);
		int          pick;
		int          width;
		int          top;
		logic [15:0] a;
		logic [15:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			a = 16'($urandom);
			b = 16'($urandom);
			if (a < b) begin
				lo = b;
				hi = a;
			end else begin
				lo = a;
				hi = b;
			end
		end else begin
			if (pick < 22) begin
				lo    = 16'($urandom_range(0, 16));
				width = $urandom_range(0, 40);
			end else if (pick < 27) begin
				lo    = 16'($urandom_range(0, 8191));
				width = $urandom_range(25, 200);
			end else begin
				lo    = 16'($urandom_range(0, 65535));
				width = $urandom_range(0, 24);
			end
			top = int'(lo) + width;
			hi  = (top > 65535) ? 16'hFFFF : top[15:0];
		end
	endtask

	initial begin
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
		req_if.valid       = 1'b0;
		req_if.range_start = '0;
		req_if.range_end   = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty and reversed ranges, the smallest values, and both ends of the field.
		send_range(16'd0, 16'd0);
		send_range(16'hFFFF, 16'hFFFF);
		send_range(16'hFFFF, 16'd0);
		send_range(16'd100, 16'd50);
		send_range(16'd0, 16'd1);
		send_range(16'd1, 16'd2);
		send_range(16'd0, 16'd2);
		send_range(16'd2, 16'd3);
		send_range(16'd3, 16'd4);
		send_range(16'd0, 16'd4);
		send_range(16'd4, 16'd5);
		send_range(16'd9, 16'd10);
		send_range(16'd25, 16'd26);
		send_range(16'd0, 16'd100);
		send_range(16'd65521, 16'hFFFF);
		send_range(16'hFFFE, 16'hFFFF);
		send_range(16'hFF00, 16'hFFFF);
		send_range(16'h8000, 16'h8020);
		send_range(16'h5555, 16'h5575);
		send_range(16'hAAAA, 16'hAACA);
		send_range(16'd0, 16'd2000);

		// The sender waits for every count before going on.
		wait_drained();

		// Responses held off while short ranges keep coming, so the input must
		// stall well before the hold-off ends.
		hold_rsp_go = 1'b1;
		tx_idle_en  = 1'b0;
		send_range(16'd0, 16'd10);
		send_range(16'd10, 16'd20);
		send_range(16'd20, 16'd30);
		send_range(16'd30, 16'd40);
		send_range(16'd40, 16'd50);
		send_range(16'd50, 16'd60);
		tx_idle_en = 1'b1;

		for (int i = 0; i < 120; i++) begin
			tx_idle_en = !(i >= 40 && i < 80);
			rx_idle_en = !(i >= 40 && i < 80);
			pick_range(lo, hi);
			send_range(lo, hi);
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;

		wait_drained();
		repeat (50) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("prime_count_in_range_core verification clean");
		end else begin
			$display("prime_count_in_range_core verification failed");
		end
		$finish;
	end

	initial begin
		#200_000_000;
		$display("prime_count_in_range_core verification failed");
		$finish;
	end

endmodule

@@ prime_count_in_range_core.f @@
sv/pcir_pkg.sv
sv/pcir_if.sv
sv/pcir_rem_unit.sv
sv/prime_count_in_range_core.sv
verif/pcir_count_checker.sv
verif/tb_prime_count_in_range_core.sv
